/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* src/tpfg_pkg.sv */
`default_nettype none

package tpfg_pkg;

	localparam int NODE_COUNT_DEF   = 128;
	localparam int MAX_CHILDREN_DEF = 5;

	// fixed field widths of the item ports
	localparam int OP_W   = 2;
	localparam int NODE_W = 7;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_QUERY = 2'd2
	} opcode_t;

endpackage

`default_nettype wire

/* src/tree_preorder_first_greater.sv */
//  channel | handshake            | fields
//  --------+----------------------+-------------------------------------------------------
//  in      | in_valid, in_ready   | opcode, parent_node, child_node, last_edge, start_node
//  out     | out_valid, out_ready | found, result_node, overflow
//
//  clear: the count memory is swept to zero, then the result is loaded
//  add edge: count read, then table and count write, then result load
//  query: visited sweep, then per pop a stack read, count read and visited check, per child
//    a list read and push, a list-end step, then the empty-stack pop when nothing is found and the result load
//  after reset the count memory is swept, with in_ready low
//  in_ready is high only when idle; a finished item waits while out_ready is low
`default_nettype none

module tree_preorder_first_greater #(
	parameter int NODE_COUNT   = tpfg_pkg::NODE_COUNT_DEF,
	parameter int MAX_CHILDREN = tpfg_pkg::MAX_CHILDREN_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [tpfg_pkg::OP_W-1:0]   opcode,
	input  wire logic [tpfg_pkg::NODE_W-1:0] parent_node,
	input  wire logic [tpfg_pkg::NODE_W-1:0] child_node,
	input  wire logic                        last_edge,
	input  wire logic [tpfg_pkg::NODE_W-1:0] start_node,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             found,
	output logic      [tpfg_pkg::NODE_W-1:0] result_node,
	output logic                             overflow
);
	import tpfg_pkg::*;

	localparam int IDX_W = $clog2(NODE_COUNT);
	localparam int SP_W  = $clog2(NODE_COUNT + 1);
	localparam int CNT_W = $clog2(MAX_CHILDREN + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);

	// sequencer states, one-hot
	typedef enum logic [12:0] {
		S_INIT   = 13'b0000000000001,  // count sweep after reset
		S_IDLE   = 13'b0000000000010,
		S_CLR    = 13'b0000000000100,  // count sweep for a clear item
		S_ADD_RD = 13'b0000000001000,
		S_ADD_WR = 13'b0000000010000,
		S_VCLR   = 13'b0000000100000,  // visited sweep, start pushed
		S_POP    = 13'b0000001000000,
		S_CUR    = 13'b0000010000000,
		S_CHK    = 13'b0000100000000,
		S_KID    = 13'b0001000000000,
		S_KRD    = 13'b0010000000000,
		S_PUSH   = 13'b0100000000000,
		S_RESP   = 13'b1000000000000
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  sweep_q;
	logic [SP_W-1:0]   sp_q;
	logic [SP_W-1:0]   sp_dec;
	logic              out_valid_q;

	// item fields and walk registers
	logic [NODE_W-1:0] parent_q;
	logic [NODE_W-1:0] child_q;
	logic [NODE_W-1:0] start_q;
	logic [NODE_W-1:0] cur_q;
	logic [NODE_W-1:0] ch_q;
	logic [CNT_W-1:0]  k_q;
	logic [CNT_W-1:0]  k_dec;
	logic              res_found_q;
	logic [NODE_W-1:0] res_node_q;
	logic              res_ovf_q;
	logic              found_q;
	logic [NODE_W-1:0] result_q;
	logic              overflow_q;

	// visited marks and walk stack
	logic              visited_mem_q [NODE_COUNT];
	logic              vis_rdata_q;
	logic [NODE_W-1:0] stack_mem_q [NODE_COUNT];
	logic [NODE_W-1:0] stk_rdata_q;

	// memory controls
	logic              cnt_we;
	logic [IDX_W-1:0]  cnt_waddr;
	logic [CNT_W-1:0]  cnt_wdata;
	logic [IDX_W-1:0]  cnt_raddr;
	logic [CNT_W-1:0]  cnt_rdata;
	logic              tab_we;
	logic [IDX_W-1:0]  tab_wnode;
	logic [CNT_W-1:0]  tab_wslot;
	logic [IDX_W-1:0]  tab_rnode;
	logic [CNT_W-1:0]  tab_rslot;
	logic [NODE_W-1:0] tab_rdata;
	logic              vis_we;
	logic [IDX_W-1:0]  vis_waddr;
	logic              vis_wdata;
	logic [IDX_W-1:0]  vis_raddr;
	logic              stk_we;
	logic [IDX_W-1:0]  stk_waddr;
	logic [NODE_W-1:0] stk_wdata;
	logic [IDX_W-1:0]  stk_raddr;

	logic              list_full;
	logic              push_ok;
	logic              sweep_done;

	function automatic logic node_ok(input logic [NODE_W-1:0] n);
		return 32'(n) < NODE_COUNT;
	endfunction

	function automatic logic [IDX_W-1:0] to_idx(input logic [NODE_W-1:0] n);
		return IDX_W'(32'(n));
	endfunction

	assign sp_dec     = sp_q - 1'b1;
	assign k_dec      = k_q - 1'b1;
	assign sweep_done = (sweep_q == LAST_IDX);
	assign list_full  = (32'(cnt_rdata) >= MAX_CHILDREN);
	// a child is pushed only if unvisited and the stack has room
	assign push_ok    = !vis_rdata_q && node_ok(ch_q) && (32'(sp_q) < NODE_COUNT);

	// child lists and counts
	tpfg_store #(
		.NODE_COUNT   (NODE_COUNT),
		.MAX_CHILDREN (MAX_CHILDREN),
		.IDX_W        (IDX_W),
		.CNT_W        (CNT_W)
	) u_store (
		.clk       (clk),
		.cnt_we    (cnt_we),
		.cnt_waddr (cnt_waddr),
		.cnt_wdata (cnt_wdata),
		.cnt_raddr (cnt_raddr),
		.cnt_rdata (cnt_rdata),
		.tab_we    (tab_we),
		.tab_wnode (tab_wnode),
		.tab_wslot (tab_wslot),
		.tab_wdata (child_q),
		.tab_rnode (tab_rnode),
		.tab_rslot (tab_rslot),
		.tab_rdata (tab_rdata)
	);

	// memory port steering per sequencer state
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = sweep_q;
		cnt_wdata = '0;
		cnt_raddr = to_idx(parent_q);
		tab_we    = 1'b0;
		tab_wnode = to_idx(parent_q);
		tab_wslot = cnt_rdata;
		tab_rnode = to_idx(cur_q);
		tab_rslot = k_dec;
		vis_we    = 1'b0;
		vis_waddr = sweep_q;
		vis_wdata = 1'b0;
		vis_raddr = to_idx(stk_rdata_q);
		stk_we    = 1'b0;
		stk_waddr = sp_q[IDX_W-1:0];
		stk_wdata = ch_q;
		stk_raddr = sp_dec[IDX_W-1:0];
		case (state_q)
			S_INIT, S_CLR: begin
				cnt_we = 1'b1;
			end
			S_ADD_WR: begin
				// append at the current count unless the list is full
				if (!list_full) begin
					cnt_we    = 1'b1;
					cnt_waddr = to_idx(parent_q);
					cnt_wdata = CNT_W'(cnt_rdata + 1'b1);
					tab_we    = 1'b1;
				end
			end
			S_VCLR: begin
				vis_we    = 1'b1;
				// start node sits at the bottom of the stack
				stk_we    = 1'b1;
				stk_waddr = '0;
				stk_wdata = start_q;
			end
			S_CUR: begin
				cnt_raddr = to_idx(stk_rdata_q);
			end
			S_CHK: begin
				if (!vis_rdata_q) begin
					vis_we    = 1'b1;
					vis_waddr = to_idx(cur_q);
					vis_wdata = 1'b1;
				end
			end
			S_KRD: begin
				vis_raddr = to_idx(tab_rdata);
			end
			S_PUSH: begin
				stk_we = push_ok;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			visited_mem_q[vis_waddr] <= vis_wdata;
		end
		vis_rdata_q <= visited_mem_q[vis_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem_q[stk_waddr] <= stk_wdata;
		end
		stk_rdata_q <= stack_mem_q[stk_raddr];
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			sweep_q     <= '0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a result taken while the next one is ready is replaced in S_RESP
			if (out_valid_q && out_ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					sweep_q <= sweep_done ? '0 : sweep_q + 1'b1;
					if (sweep_done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						case (opcode)
							OP_CLEAR: begin
								state_q <= S_CLR;
							end
							OP_ADD: begin
								// edges naming a node outside the tree are ignored
								state_q <= (node_ok(parent_node) && node_ok(child_node))
									? S_ADD_RD : S_RESP;
							end
							OP_QUERY: begin
								state_q <= node_ok(start_node) ? S_VCLR : S_RESP;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_CLR: begin
					sweep_q <= sweep_done ? '0 : sweep_q + 1'b1;
					if (sweep_done) begin
						state_q <= S_RESP;
					end
				end
				S_ADD_RD: begin
					state_q <= S_ADD_WR;
				end
				S_ADD_WR: begin
					state_q <= S_RESP;
				end
				S_VCLR: begin
					sweep_q <= sweep_done ? '0 : sweep_q + 1'b1;
					if (sweep_done) begin
						sp_q    <= SP_W'(1);
						state_q <= S_POP;
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						state_q <= S_RESP;
					end else begin
						sp_q    <= sp_dec;
						state_q <= S_CUR;
					end
				end
				S_CUR: begin
					state_q <= node_ok(stk_rdata_q) ? S_CHK : S_POP;
				end
				S_CHK: begin
					if (vis_rdata_q) begin
						state_q <= S_POP;
					end else if (cur_q > start_q) begin
						state_q <= S_RESP;
					end else begin
						state_q <= S_KID;
					end
				end
				S_KID: begin
					// children walked from last to first
					state_q <= (k_q == '0) ? S_POP : S_KRD;
				end
				S_KRD: begin
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (push_ok) begin
						sp_q <= sp_q + 1'b1;
					end
					state_q <= S_KID;
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item fields, walk data and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					parent_q    <= parent_node;
					child_q     <= child_node;
					start_q     <= start_node;
					res_found_q <= 1'b0;
					res_node_q  <= '0;
					res_ovf_q   <= 1'b0;
				end
			end
			S_ADD_WR: begin
				res_ovf_q <= list_full;
			end
			S_CUR: begin
				cur_q <= stk_rdata_q;
			end
			S_CHK: begin
				if (!vis_rdata_q && cur_q > start_q) begin
					res_found_q <= 1'b1;
					res_node_q  <= cur_q;
				end
				k_q <= cnt_rdata;
			end
			S_KID: begin
				k_q <= k_dec;
			end
			S_KRD: begin
				ch_q <= tab_rdata;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					found_q    <= res_found_q;
					result_q   <= res_node_q;
					overflow_q <= res_ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign result_node = result_q;
	assign overflow    = overflow_q;

endmodule

`default_nettype wire

/* src/tpfg_store.sv */
`default_nettype none

module tpfg_store #(
	parameter int NODE_COUNT   = tpfg_pkg::NODE_COUNT_DEF,
	parameter int MAX_CHILDREN = tpfg_pkg::MAX_CHILDREN_DEF,
	parameter int IDX_W        = $clog2(NODE_COUNT),
	parameter int CNT_W        = $clog2(MAX_CHILDREN + 1)
) (
	input  wire logic                        clk,
	// child count per node
	input  wire logic                        cnt_we,
	input  wire logic [IDX_W-1:0]            cnt_waddr,
	input  wire logic [CNT_W-1:0]            cnt_wdata,
	input  wire logic [IDX_W-1:0]            cnt_raddr,
	output logic      [CNT_W-1:0]            cnt_rdata,
	// child lists, addressed by node and slot
	input  wire logic                        tab_we,
	input  wire logic [IDX_W-1:0]            tab_wnode,
	input  wire logic [CNT_W-1:0]            tab_wslot,
	input  wire logic [tpfg_pkg::NODE_W-1:0] tab_wdata,
	input  wire logic [IDX_W-1:0]            tab_rnode,
	input  wire logic [CNT_W-1:0]            tab_rslot,
	output logic      [tpfg_pkg::NODE_W-1:0] tab_rdata
);
	import tpfg_pkg::*;

	localparam int TAB_DEPTH = NODE_COUNT * MAX_CHILDREN;
	localparam int TAB_W     = $clog2(TAB_DEPTH);

	logic [CNT_W-1:0]  count_mem_q [NODE_COUNT];
	logic [NODE_W-1:0] table_mem_q [TAB_DEPTH];
	logic [CNT_W-1:0]  cnt_rdata_q;
	logic [NODE_W-1:0] tab_rdata_q;
	logic [TAB_W-1:0]  tab_waddr;
	logic [TAB_W-1:0]  tab_raddr;

	// flat row address: node times list length plus slot
	assign tab_waddr = TAB_W'(32'(tab_wnode) * MAX_CHILDREN + 32'(tab_wslot));
	assign tab_raddr = TAB_W'(32'(tab_rnode) * MAX_CHILDREN + 32'(tab_rslot));

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			count_mem_q[cnt_waddr] <= cnt_wdata;
		end
		cnt_rdata_q <= count_mem_q[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (tab_we) begin
			table_mem_q[tab_waddr] <= tab_wdata;
		end
		tab_rdata_q <= table_mem_q[tab_raddr];
	end

	assign cnt_rdata = cnt_rdata_q;
	assign tab_rdata = tab_rdata_q;

endmodule

`default_nettype wire

/* src/tpfg_check.sv */
`default_nettype none
`include "assert_macros.svh"

module tpfg_check (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic                        found,
	input wire logic [tpfg_pkg::NODE_W-1:0] result_node,
	input wire logic                        overflow
);
	import tpfg_pkg::*;

	// stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(found) && $stable(result_node) && $stable(overflow))
	// taking an item drops in_ready, as the block leaves idle
	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready)
	// a miss reports node zero
	`ASSERT_IMPLY(a_miss_zero, clk, arst_n, out_valid && !found, result_node == '0)
	// no result flags both found and overflow
	`ASSERT_IMPLY(a_flag_excl, clk, arst_n, out_valid, !(found && overflow))
	// count sweep runs right after reset
	`ASSERT_NEXT(a_init_busy, clk, arst_n, $rose(arst_n), !in_ready)

endmodule

bind tree_preorder_first_greater tpfg_check u_tpfg_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.found       (found),
	.result_node (result_node),
	.overflow    (overflow)
);

`default_nettype wire

/* tb/tb_tree_preorder_first_greater.sv */
module tb_tree_preorder_first_greater;
	timeunit 1ns;
	timeprecision 1ps;

	import tpfg_pkg::*;

	localparam int NODES = NODE_COUNT_DEF;
	localparam int MAX_KIDS = MAX_CHILDREN_DEF;
	// opcode with no meaning, block answers with an all-zero result
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	// stop generating once this many non-ignored items are queued
	localparam int ITEM_TARGET = 1100;
	// quiet cycles after the last result, to catch stray outputs
	localparam int DRAIN_CYCLES = 300;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [NODE_W-1:0] parent;
		logic [NODE_W-1:0] child;
		logic              last;
		logic [NODE_W-1:0] start;
	} tree_item_t;

	typedef struct packed {
		logic              found;
		logic [NODE_W-1:0] node;
		logic              overflow;
	} walk_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	tree_item_t held_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic found;
	logic [NODE_W-1:0] result_node;
	logic overflow;

	// items waiting to be driven, and results owed by the block in order
	tree_item_t item_queue[$];
	walk_result_t expected_results[$];
	int counted_items = 0;
	int errors = 0;

	// shadow copy of the block's child lists
	logic [NODE_W-1:0] kid_table [NODES][MAX_KIDS];
	int unsigned kid_count [NODES];

	// scratch for building shuffled trees
	int node_perm [NODES];

	// sender burst shaping
	int gap_left = 0;
	int burst_left = 1;

	// receiver stall pattern, rotated one bit per cycle
	logic [15:0] ready_pattern = 16'hffff;
	int pattern_step = 0;

	tree_preorder_first_greater i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (held_item.op),
		.parent_node (held_item.parent),
		.child_node  (held_item.child),
		.last_edge   (held_item.last),
		.start_node  (held_item.start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.result_node (result_node),
		.overflow    (overflow)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// apply one item to the shadow tree and work out the block's answer
	function automatic walk_result_t apply_tree_op(tree_item_t it);
		walk_result_t res;
		bit seen [NODES];
		int unsigned stack [NODES];
		int unsigned depth;
		int unsigned cur;
		int unsigned cnt;
		res = '0;
		case (it.op)
			OP_CLEAR: begin
				// only the counts are emptied, old table entries stay unread
				foreach (kid_count[i]) kid_count[i] = 0;
			end
			OP_ADD: begin
				if (it.parent < NODES && it.child < NODES) begin
					cnt = kid_count[it.parent];
					if (cnt >= MAX_KIDS) begin
						res.overflow = 1'b1;
					end else begin
						kid_table[it.parent][cnt] = it.child;
						kid_count[it.parent] = cnt + 1;
					end
				end
			end
			OP_QUERY: begin
				foreach (seen[i]) seen[i] = 1'b0;
				depth = 0;
				if (it.start < NODES) begin
					stack[0] = 32'(it.start);
					depth = 1;
				end
				while (depth != 0 && !res.found) begin
					depth--;
					cur = stack[depth];
					if (!seen[cur]) begin
						seen[cur] = 1'b1;
						if (cur > it.start) begin
							res.found = 1'b1;
							res.node = NODE_W'(cur);
						end else begin
							// reverse push so the list is walked in insertion order,
							// pushes onto a full stack are lost
							for (int k = kid_count[cur]; k > 0; k--) begin
								if (!seen[kid_table[cur][k-1]] && depth < NODES) begin
									stack[depth] = 32'(kid_table[cur][k-1]);
									depth++;
								end
							end
						end
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic int rand_node();
		return $urandom_range(0, NODES - 1);
	endfunction

	task automatic queue_item(logic [OP_W-1:0] op, int parent, int child, bit last, int start);
		tree_item_t it;
		it.op = op;
		it.parent = parent[NODE_W-1:0];
		it.child = child[NODE_W-1:0];
		it.last = last;
		it.start = start[NODE_W-1:0];
		item_queue.push_back(it);
		// ignored opcodes do not count toward the stimulus size
		if (op != OP_UNUSED) counted_items++;
	endtask

	// query with random don't-care fields
	task automatic queue_query(int start);
		queue_item(OP_QUERY, rand_node(), rand_node(), 1'($urandom_range(0, 1)), start);
	endtask

	// random tree over n shuffled node numbers; a parent may collect more
	// children than fit, which exercises the overflow path
	task automatic load_tree(int n);
		int j;
		int tmp;
		for (int i = 0; i < NODES; i++) node_perm[i] = i;
		for (int i = NODES - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = node_perm[i];
			node_perm[i] = node_perm[j];
			node_perm[j] = tmp;
		end
		for (int i = 1; i < n; i++)
			queue_item(OP_ADD, node_perm[$urandom_range(0, i - 1)], node_perm[i], i == n - 1,
				rand_node());
	endtask

	// descending chain where each node points to the next five below it;
	// a walk from the top finds nothing greater and piles up duplicate
	// pushes until the stack is full
	task automatic load_chain(int top, int len);
		for (int i = 0; i < len; i++)
			for (int c = 1; c <= MAX_KIDS; c++)
				queue_item(OP_ADD, top - i, top - i - c, i == len - 1 && c == MAX_KIDS,
					rand_node());
	endtask

	task automatic report_mismatch(string field, logic [NODE_W-1:0] want_v,
		logic [NODE_W-1:0] got_v);
		$display("%0d ns: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
		errors++;
	endtask

	// driver: present the next item once the current one is taken,
	// with bursts and gaps of random length
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			// item taken at this edge, its result is now owed
			if (in_valid) expected_results.push_back(apply_tree_op(held_item));
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (item_queue.size() != 0) begin
				held_item <= item_queue.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					// end of burst: pick the next burst and the gap before it
					burst_left <= $urandom_range(1, 24);
					if ($urandom_range(0, 3) == 0)
						gap_left <= 0;
					else if ($urandom_range(0, 5) == 0)
						gap_left <= $urandom_range(20, 60);
					else
						gap_left <= $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: out_ready follows a 16-bit pattern, renewed each lap,
	// sometimes all ready and sometimes a full stall
	always @(posedge clk) begin
		out_ready <= ready_pattern[0];
		if (pattern_step == 15) begin
			pattern_step <= 0;
			case ($urandom_range(0, 5))
				0, 1: ready_pattern <= 16'hffff;
				2: ready_pattern <= 16'h0000;
				default: ready_pattern <= 16'($urandom);
			endcase
		end else begin
			pattern_step <= pattern_step + 1;
			ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
		end
	end

	// monitor: every taken result against the oldest owed one
	always @(posedge clk) begin : check_results
		walk_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0d ns: unexpected result, expected none, actual found=%b node=%0d overflow=%b",
					$time, found, result_node, overflow);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (found !== want.found) report_mismatch("found", want.found, found);
				if (result_node !== want.node) report_mismatch("result_node", want.node, result_node);
				if (overflow !== want.overflow) report_mismatch("overflow", want.overflow, overflow);
			end
		end
	end

	initial begin
		int n;
		int pick;
		int top;
		int len;

		// directed: empty tree, nothing to find
		queue_query(0);
		// unused opcode with every field at its top value
		queue_item(OP_UNUSED, NODES - 1, NODES - 1, 1'b1, NODES - 1);
		// fill node 0's list, then one more edge which must be dropped
		queue_item(OP_ADD, 0, 127, 1'b0, 0);
		queue_item(OP_ADD, 0, 1, 1'b0, 127);
		queue_item(OP_ADD, 0, 64, 1'b0, 0);
		queue_item(OP_ADD, 0, 5, 1'b0, 0);
		queue_item(OP_ADD, 0, 3, 1'b0, 0);
		queue_item(OP_ADD, 0, 9, 1'b1, 0);
		// first child in list order wins
		queue_query(0);
		// back edges and a self loop, walk from the top finds nothing
		queue_item(OP_ADD, 127, 0, 1'b0, 0);
		queue_item(OP_ADD, 1, 0, 1'b0, 0);
		queue_item(OP_ADD, 3, 3, 1'b1, 0);
		queue_query(127);
		// leaf start
		queue_query(64);
		// found two levels down
		queue_item(OP_ADD, 5, 2, 1'b0, 0);
		queue_item(OP_ADD, 2, 7, 1'b1, 0);
		queue_query(5);
		queue_query(2);
		// clear with all fields high, then the old edges are gone
		queue_item(OP_CLEAR, 127, 127, 1'b1, 127);
		queue_query(0);
		// self loop on node 0 with all-zero fields
		queue_item(OP_ADD, 0, 0, 1'b0, 0);
		queue_query(0);
		queue_item(OP_UNUSED, 0, 0, 1'b0, 0);

		// full-stack walk at least once
		top = $urandom_range(50, NODES - 1);
		len = $urandom_range(36, 45);
		queue_item(OP_CLEAR, rand_node(), rand_node(), 1'($urandom_range(0, 1)), rand_node());
		load_chain(top, len);
		queue_query(top);

		// random part: mostly tree loads followed by queries
		while (counted_items < ITEM_TARGET) begin
			pick = $urandom_range(0, 19);
			if (pick < 12) begin
				// sometimes append onto the previous tree instead of clearing
				if ($urandom_range(0, 4) != 0)
					queue_item(OP_CLEAR, rand_node(), rand_node(), 1'($urandom_range(0, 1)),
						rand_node());
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(41, NODES) : $urandom_range(2, 40);
				load_tree(n);
				// extra non-tree edges: cycles, cross links, duplicates
				if ($urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, n))
						queue_item(OP_ADD, node_perm[$urandom_range(0, n - 1)],
							node_perm[$urandom_range(0, n - 1)], 1'b0, rand_node());
				repeat ($urandom_range(2, 8))
					queue_query(($urandom_range(0, 3) == 0) ? rand_node() :
						node_perm[$urandom_range(0, n - 1)]);
			end else if (pick < 13) begin
				top = $urandom_range(50, NODES - 1);
				len = $urandom_range(30, 45);
				queue_item(OP_CLEAR, rand_node(), rand_node(), 1'($urandom_range(0, 1)),
					rand_node());
				load_chain(top, len);
				queue_query(top);
				queue_query(top - $urandom_range(0, len));
				queue_query(rand_node());
			end else begin
				// noise: any opcode with fully random fields
				repeat ($urandom_range(1, 6)) begin
					pick = $urandom_range(0, 15);
					queue_item((pick == 0) ? OP_CLEAR : (pick < 4) ? OP_UNUSED :
						(pick < 11) ? OP_ADD : OP_QUERY,
						rand_node(), rand_node(), 1'($urandom_range(0, 1)), rand_node());
				end
			end
		end

		// reset, released on a clock edge
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// all items taken, all results in, then a quiet stretch
		while (item_queue.size() != 0 || in_valid) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#600_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/tpfg_pkg.sv
src/tpfg_store.sv
src/tree_preorder_first_greater.sv
src/tpfg_check.sv
tb/tb_tree_preorder_first_greater.sv
